// ===== src/atrp_pkg.sv =====
// Package for the ASCII triple record parser.
// Character codes, the decoded byte class type and the byte classifier.
// No dependencies.
package atrp_pkg;

    localparam int VALUE_BITS_DEFAULT = 16;

    localparam logic [7:0] CHAR_DATA  = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_INFO  = 8'h49;  // 'I'
    localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic       marker;     // 'D' or 'I'
        logic       data_mark;  // 'D'
        logic       space;
        logic       blank;      // tab .. carriage return
        logic       plus;
        logic       minus;
        logic       digit;
        logic [3:0] digit_val;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        logic [7:0]  off;
        off         = b - CHAR_ZERO;
        c.data_mark = (b == CHAR_DATA);
        c.marker    = (b == CHAR_DATA) || (b == CHAR_INFO);
        c.space     = (b == CHAR_SPACE);
        c.blank     = (b >= CHAR_TAB) && (b <= CHAR_CR);
        c.plus      = (b == CHAR_PLUS);
        c.minus     = (b == CHAR_MINUS);
        c.digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        c.digit_val = off[3:0];
        return c;
    endfunction

endpackage

// ===== src/ascii_triple_record_parser.sv =====
// A closing 'D' or 'I' passes through the input register and then loads the result register behind res_valid.
// Throughput: one byte per cycle; the input register holds back only while it
// carries a closing marker and the result register is full and stalled.
// Reset (rst_n low, asynchronous): hunting for the first marker, fields cleared,
// no item held in the input or result register.
// Depends on atrp_pkg and atrp_parser.
module ascii_triple_record_parser
    import atrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rx_valid,
    output logic                         rx_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [VALUE_BITS-1:0] first_value,
    output logic signed [VALUE_BITS-1:0] second_value,
    output logic signed [VALUE_BITS-1:0] third_value
);

    logic        s1_valid_reg, s1_valid_next;
    byte_class_t s1_class_reg;
    logic        res_valid_reg, res_valid_next;
    logic signed [VALUE_BITS-1:0] first_reg, second_reg, third_reg;

    logic emit;
    logic res_free;
    logic advance;
    logic rx_take;
    logic signed [VALUE_BITS-1:0] acc0, acc1, acc2;

    atrp_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cls   (s1_class_reg),
        .emit  (emit),
        .acc0  (acc0),
        .acc1  (acc1),
        .acc2  (acc2)
    );

    assign res_free = !res_valid_reg || !res_stall;
    assign advance  = s1_valid_reg && (!emit || res_free);
    assign rx_stall = s1_valid_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            s1_class_reg <= classify(rx_byte);
        end
        // record values are taken before the marker clears them
        if (advance && emit)
        begin
            first_reg  <= acc0;
            second_reg <= acc1;
            third_reg  <= acc2;
        end
    end

    assign res_valid    = res_valid_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign third_value  = third_reg;

endmodule

// ===== src/atrp_digit_acc.sv =====
// Decimal digit accumulate with saturation: acc * 10 +/- digit.
// Depends on atrp_pkg.
module atrp_digit_acc
    import atrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic signed [VALUE_BITS-1:0] acc,
    input  logic                         negative,
    input  logic [3:0]                   digit,
    output logic signed [VALUE_BITS-1:0] result
);

    localparam int W = VALUE_BITS + 5;

    localparam logic signed [W-1:0] MAX_W = {{6{1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {{6{1'b1}}, {(VALUE_BITS-1){1'b0}}};

    logic signed [W-1:0] wide;
    logic signed [W-1:0] scaled;
    logic signed [W-1:0] dig_w;
    logic signed [W-1:0] sum;

    always_comb
    begin
        wide   = {{5{acc[VALUE_BITS-1]}}, acc};
        // x10 as x8 + x2
        scaled = (wide <<< 3) + (wide <<< 1);
        dig_w  = $signed({{(W-4){1'b0}}, digit});
        sum    = negative ? (scaled - dig_w) : (scaled + dig_w);
        if (negative && (sum < MIN_W))
        begin
            result = MIN_W[VALUE_BITS-1:0];
        end
        else if (!negative && (sum > MAX_W))
        begin
            result = MAX_W[VALUE_BITS-1:0];
        end
        else
        begin
            result = sum[VALUE_BITS-1:0];
        end
    end

endmodule

// ===== src/atrp_parser.sv =====
// Record and field state of the parser, updated once per stepped item.
// Depends on atrp_pkg and atrp_digit_acc.
module atrp_parser
    import atrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  byte_class_t                  cls,
    output logic                         emit,
    output logic signed [VALUE_BITS-1:0] acc0,
    output logic signed [VALUE_BITS-1:0] acc1,
    output logic signed [VALUE_BITS-1:0] acc2
);

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_INFO = 2'd2;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    logic [1:0] mode_reg, mode_next;
    logic       pos_reg, pos_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       neg_reg, neg_next;
    logic signed [VALUE_BITS-1:0] acc_reg [3];
    logic signed [VALUE_BITS-1:0] acc_next [3];

    logic signed [VALUE_BITS-1:0] cur_acc;
    logic signed [VALUE_BITS-1:0] new_acc;
    logic                         take;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_acc = acc_reg[0];
            2'd1:    cur_acc = acc_reg[1];
            default: cur_acc = acc_reg[2];
        endcase
    end

    atrp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_digit (
        .acc      (cur_acc),
        .negative (neg_reg),
        .digit    (cls.digit_val),
        .result   (new_acc)
    );

    assign emit = cls.marker && (mode_reg == MODE_DATA);
    assign acc0 = acc_reg[0];
    assign acc1 = acc_reg[1];
    assign acc2 = acc_reg[2];

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        take       = 1'b0;
        if (cls.marker)
        begin
            mode_next  = cls.data_mark ? MODE_DATA : MODE_INFO;
            pos_next   = 1'b0;
            idx_next   = 2'd0;
            phase_next = PH_START;
            neg_next   = 1'b0;
        end
        else if (mode_reg == MODE_DATA)
        begin
            if (!pos_reg)
            begin
                pos_next = 1'b1;    // byte after 'D' is skipped
            end
            else if (cls.space)
            begin
                if (idx_reg < 2'd2)
                begin
                    idx_next   = idx_reg + 2'd1;
                    phase_next = PH_START;
                    neg_next   = 1'b0;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (cls.blank)
                        begin
                            phase_next = PH_START;
                        end
                        else if (cls.plus)
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (cls.minus)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_SIGN;
                        end
                        else if (cls.digit)
                        begin
                            take       = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (cls.digit)
                        begin
                            take       = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            if (cls.marker)
            begin
                acc_next[i] = '0;
            end
            else if (take && (idx_reg == 2'(i)))
            begin
                acc_next[i] = new_acc;
            end
            else
            begin
                acc_next[i] = acc_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            pos_reg    <= 1'b0;
            idx_reg    <= 2'd0;
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            acc_reg[0] <= acc_next[0];
            acc_reg[1] <= acc_next[1];
            acc_reg[2] <= acc_next[2];
        end
    end

endmodule

// ===== src/atrp_checker.sv =====
// Port-level checks for ascii_triple_record_parser, bound to the top level.
// Depends on atrp_pkg.
module atrp_checker
    import atrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rx_valid,
    input logic                         rx_stall,
    input logic [7:0]                   rx_byte,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic signed [VALUE_BITS-1:0] first_value,
    input logic signed [VALUE_BITS-1:0] second_value,
    input logic signed [VALUE_BITS-1:0] third_value
);

    // held result keeps its values
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(first_value)
            && $stable(second_value) && $stable(third_value))
    else $error("stalled result changed");

    // a stalled input item stays offered unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
    else $error("stalled input item changed");

    // input backpressure only comes from a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> res_valid && res_stall)
    else $error("input stalled while result side is free");

    // a byte waiting at the input with the result register empty is never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !rx_stall)
    else $error("input stalled with empty result register");

    assert property (@(posedge clk)
        !rst_n |-> !res_valid && !rx_stall)
    else $error("outputs active during reset");

endmodule

bind ascii_triple_record_parser atrp_checker #(.VALUE_BITS(VALUE_BITS)) u_atrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .first_value  (first_value),
    .second_value (second_value),
    .third_value  (third_value)
);
